>>> sv/etc2_pkg.sv
// ----------------------------------------------------------------------------
// etc2_pkg
// Shared types, mode codes, tables and helpers for the ETC2 RGB block decoder.
// ----------------------------------------------------------------------------
package etc2_pkg;

   localparam int BLOCK_W  = 64;
   localparam int CHAN_W   = 8;
   localparam int MODE_W   = 3;
   localparam int PIXELS   = 16;
   localparam int POS_W    = 4;
   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = 1;
   localparam int Q_CNT_W  = 2;
   localparam int SUM_W    = 13;

   localparam logic [MODE_W-1:0] MODE_INDIV  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DIFF   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_T      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_H      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PLANAR = 3'd4;

   // intensity modifiers: +small, +large, -small, -large
   localparam logic signed [8:0] MOD_TAB [0:7][0:3] = '{
      '{ 9'sd2,   9'sd8,   -9'sd2,  -9'sd8  },
      '{ 9'sd5,   9'sd17,  -9'sd5,  -9'sd17 },
      '{ 9'sd9,   9'sd29,  -9'sd9,  -9'sd29 },
      '{ 9'sd13,  9'sd42,  -9'sd13, -9'sd42 },
      '{ 9'sd18,  9'sd60,  -9'sd18, -9'sd60 },
      '{ 9'sd24,  9'sd80,  -9'sd24, -9'sd80 },
      '{ 9'sd33,  9'sd106, -9'sd33, -9'sd106},
      '{ 9'sd47,  9'sd183, -9'sd47, -9'sd183}
   };

   // T and H paint distances
   localparam logic [6:0] TH_STEP [0:7] = '{
      7'd3, 7'd6, 7'd11, 7'd16, 7'd23, 7'd32, 7'd41, 7'd64
   };

   // classified block, passed from front to back
   typedef struct packed {
      logic [MODE_W-1:0]               mode;
      logic [PIXELS-1:0]               sel_lo;
      logic [PIXELS-1:0]               sel_hi;
      logic                            flip;
      logic [2:0]                      tb0;
      logic [2:0]                      tb1;
      logic [2:0][2:0][CHAN_W-1:0]     base;   // [color][channel]
      logic [3:0][2:0][CHAN_W-1:0]     pal;    // [paint][channel]
   } blk_type;

   function automatic logic [CHAN_W-1:0] ext4(input logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [CHAN_W-1:0] ext5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [CHAN_W-1:0] ext6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [CHAN_W-1:0] ext7(input logic [6:0] v);
      return {v, v[6]};
   endfunction

   function automatic logic [CHAN_W-1:0] clamp8(input logic signed [SUM_W-1:0] v);
      logic [CHAN_W-1:0] r;
      if (v < 0) r = '0;
      else if (v > 255) r = 8'd255;
      else r = v[CHAN_W-1:0];
      return r;
   endfunction

   // clamp of an 8-bit channel plus a signed offset
   function automatic logic [CHAN_W-1:0] add_clamp(input logic [CHAN_W-1:0] c,
                                                   input logic signed [8:0] m);
      logic signed [SUM_W-1:0] s;
      s = $signed({5'b0, c}) + $signed({{4{m[8]}}, m});
      return clamp8(s);
   endfunction

endpackage

>>> sv/etc2_rgb_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// etc2_rgb_block_decoder_unit
// Decodes 64-bit ETC2 RGB blocks into sixteen RGB888 pixels each.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  block_word[63:0]
//  rsp       out        rsp_valid/rsp_ready  red, green, blue, pixel_position,
//                                            block_mode, last_pixel
//
//  The back end walks a block's pixels, one pixel per cycle while rsp is not
//  stalled; the pixel counter sets the rate, and the next block waits for it.
//  The first pixel passes the front stage, the queue and the output register.
//  Reset clears the front stage, the queue and the pixel counter.
//  A stalled rsp holds the pixel; the two-entry queue and the front stage
//  keep accepting blocks until they fill.
// ----------------------------------------------------------------------------
module etc2_rgb_block_decoder_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [etc2_pkg::BLOCK_W-1:0]   req_block_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [etc2_pkg::CHAN_W-1:0]    rsp_red,
   output logic [etc2_pkg::CHAN_W-1:0]    rsp_green,
   output logic [etc2_pkg::CHAN_W-1:0]    rsp_blue,
   output logic [etc2_pkg::POS_W-1:0]     rsp_pixel_position,
   output logic [etc2_pkg::MODE_W-1:0]    rsp_block_mode,
   output logic                           rsp_last_pixel
);
   import etc2_pkg::*;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   blk_type push_blk, pop_blk;

   etc2_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_block_word (req_block_word),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_blk       (push_blk)
   );

   etc2_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_blk   (push_blk),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_blk    (pop_blk)
   );

   etc2_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_blk            (pop_blk),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_pixel_position (rsp_pixel_position),
      .rsp_block_mode     (rsp_block_mode),
      .rsp_last_pixel     (rsp_last_pixel)
   );

endmodule

>>> sv/etc2_front.sv
// ----------------------------------------------------------------------------
// etc2_front
// Accepts compressed blocks, picks the mode and unpacks base colors and
// paint colors into one registered item for the queue.
// ----------------------------------------------------------------------------
module etc2_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [etc2_pkg::BLOCK_W-1:0]  req_block_word,
   output logic                          push_valid,
   input  logic                          push_ready,
   output etc2_pkg::blk_type             push_blk
);
   import etc2_pkg::*;

   logic              valid_ff, valid_in;
   blk_type           blk_ff, blk_in;
   logic [63:0]       w;
   logic signed [6:0] rs, gs, bs;
   logic              r_ovf, g_ovf, b_ovf;
   logic [2:0][CHAN_W-1:0] tc0, tc1, hc0, hc1;
   logic [6:0]        td, hd;
   logic              h_ge;

   assign w = req_block_word;

   // differential sums and their overflow
   always_comb begin
      rs = $signed({2'b0, w[63:59]}) + $signed({{4{w[58]}}, w[58:56]});
      gs = $signed({2'b0, w[55:51]}) + $signed({{4{w[50]}}, w[50:48]});
      bs = $signed({2'b0, w[47:43]}) + $signed({{4{w[42]}}, w[42:40]});
      r_ovf = rs[6] | rs[5];
      g_ovf = gs[6] | gs[5];
      b_ovf = bs[6] | bs[5];
   end

   // T and H base colors and distances
   always_comb begin
      tc0[0] = ext4({w[60:59], w[57:56]});
      tc0[1] = ext4(w[55:52]);
      tc0[2] = ext4(w[51:48]);
      tc1[0] = ext4(w[47:44]);
      tc1[1] = ext4(w[43:40]);
      tc1[2] = ext4(w[39:36]);
      td     = TH_STEP[{w[35:34], w[32]}];
      hc0[0] = ext4(w[62:59]);
      hc0[1] = ext4({w[58:56], w[52]});
      hc0[2] = ext4({w[51], w[49:47]});
      hc1[0] = ext4(w[46:43]);
      hc1[1] = ext4(w[42:39]);
      hc1[2] = ext4(w[38:35]);
      h_ge   = ({hc0[0], hc0[1], hc0[2]} >= {hc1[0], hc1[1], hc1[2]});
      hd     = TH_STEP[{w[34], w[32], h_ge}];
   end

   // classify and unpack
   always_comb begin
      blk_in        = '0;
      blk_in.sel_lo = w[15:0];
      blk_in.sel_hi = w[31:16];
      blk_in.flip   = w[32];
      blk_in.tb0    = w[39:37];
      blk_in.tb1    = w[36:34];
      priority if (!w[33]) begin
         blk_in.mode    = MODE_INDIV;
         // channel order in the packed vector is [2]=blue .. [0]=red
         blk_in.base[0] = {ext4(w[47:44]), ext4(w[55:52]), ext4(w[63:60])};
         blk_in.base[1] = {ext4(w[43:40]), ext4(w[51:48]), ext4(w[59:56])};
      end else if (r_ovf) begin
         blk_in.mode = MODE_T;
         for (int k = 0; k < 3; k++) begin
            blk_in.pal[0][k] = tc0[k];
            blk_in.pal[1][k] = add_clamp(tc1[k], $signed({2'b0, td}));
            blk_in.pal[2][k] = tc1[k];
            blk_in.pal[3][k] = add_clamp(tc1[k], -$signed({2'b0, td}));
         end
      end else if (g_ovf) begin
         blk_in.mode = MODE_H;
         for (int k = 0; k < 3; k++) begin
            blk_in.pal[0][k] = add_clamp(hc0[k], $signed({2'b0, hd}));
            blk_in.pal[1][k] = add_clamp(hc0[k], -$signed({2'b0, hd}));
            blk_in.pal[2][k] = add_clamp(hc1[k], $signed({2'b0, hd}));
            blk_in.pal[3][k] = add_clamp(hc1[k], -$signed({2'b0, hd}));
         end
      end else if (b_ovf) begin
         blk_in.mode       = MODE_PLANAR;
         blk_in.base[0][0] = ext6(w[62:57]);
         blk_in.base[0][1] = ext7({w[56], w[54:49]});
         blk_in.base[0][2] = ext6({w[48], w[44:43], w[41:39]});
         blk_in.base[1][0] = ext6({w[38:34], w[32]});
         blk_in.base[1][1] = ext7(w[31:25]);
         blk_in.base[1][2] = ext6(w[24:19]);
         blk_in.base[2][0] = ext6(w[18:13]);
         blk_in.base[2][1] = ext7(w[12:6]);
         blk_in.base[2][2] = ext6(w[5:0]);
      end else begin
         blk_in.mode       = MODE_DIFF;
         blk_in.base[0][0] = ext5(w[63:59]);
         blk_in.base[0][1] = ext5(w[55:51]);
         blk_in.base[0][2] = ext5(w[47:43]);
         blk_in.base[1][0] = ext5(rs[4:0]);
         blk_in.base[1][1] = ext5(gs[4:0]);
         blk_in.base[1][2] = ext5(bs[4:0]);
      end
   end

   // hold the stage until the queue takes it
   assign req_ready = !valid_ff || push_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         blk_ff <= blk_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_blk   = blk_ff;

endmodule

>>> sv/etc2_queue.sv
// ----------------------------------------------------------------------------
// etc2_queue
// Short queue of classified blocks between front and back.
// ----------------------------------------------------------------------------
module etc2_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  etc2_pkg::blk_type push_blk,
   output logic              pop_valid,
   input  logic              pop_ready,
   output etc2_pkg::blk_type pop_blk
);
   import etc2_pkg::*;

   blk_type               mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]    count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_blk    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_blk;
      end
   end

endmodule

>>> sv/etc2_back.sv
// ----------------------------------------------------------------------------
// etc2_back
// Walks the sixteen pixels of the head block, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module etc2_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  etc2_pkg::blk_type              pop_blk,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [etc2_pkg::CHAN_W-1:0]    rsp_red,
   output logic [etc2_pkg::CHAN_W-1:0]    rsp_green,
   output logic [etc2_pkg::CHAN_W-1:0]    rsp_blue,
   output logic [etc2_pkg::POS_W-1:0]     rsp_pixel_position,
   output logic [etc2_pkg::MODE_W-1:0]    rsp_block_mode,
   output logic                           rsp_last_pixel
);
   import etc2_pkg::*;

   logic [POS_W-1:0]        cnt_ff, cnt_in;
   logic                    valid_ff, valid_in;
   logic [2:0][CHAN_W-1:0]  pix_ff, pix_in;
   logic [POS_W-1:0]        pos_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic                    last_ff;
   logic                    advance;
   logic [1:0]              pick;
   logic                    half;
   logic [2:0]              tb;
   logic signed [8:0]       m;
   logic [1:0]              px, py;
   logic signed [SUM_W-1:0] dh, dv, s;

   assign advance   = pop_valid && (!valid_ff || rsp_ready);
   assign pop_ready = advance && (cnt_ff == POS_W'(PIXELS - 1));

   // pixel value for the current position
   always_comb begin
      pick = {pop_blk.sel_hi[cnt_ff], pop_blk.sel_lo[cnt_ff]};
      half = pop_blk.flip ? cnt_ff[1] : cnt_ff[3];
      tb   = half ? pop_blk.tb1 : pop_blk.tb0;
      m    = MOD_TAB[tb][pick];
      px   = cnt_ff[3:2];
      py   = cnt_ff[1:0];
      dh   = '0;
      dv   = '0;
      s    = '0;
      pix_in = '0;
      unique case (pop_blk.mode)
         MODE_INDIV, MODE_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               pix_in[k] = add_clamp(pop_blk.base[half][k], m);
            end
         end
         MODE_T, MODE_H: begin
            pix_in = pop_blk.pal[pick];
         end
         MODE_PLANAR: begin
            for (int k = 0; k < 3; k++) begin
               dh = $signed({5'b0, pop_blk.base[1][k]}) - $signed({5'b0, pop_blk.base[0][k]});
               dv = $signed({5'b0, pop_blk.base[2][k]}) - $signed({5'b0, pop_blk.base[0][k]});
               s  = SUM_W'($signed({11'b0, px}) * dh) + SUM_W'($signed({11'b0, py}) * dv)
                  + $signed({3'b0, pop_blk.base[0][k], 2'b10});
               pix_in[k] = clamp8(s >>> 2);
            end
         end
         default: begin
            pix_in = '0;
         end
      endcase
   end

   // step the pixel counter and the output valid
   always_comb begin
      cnt_in   = advance ? cnt_ff + 1'b1 : cnt_ff;
      valid_in = valid_ff;
      if (advance) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff  <= pix_in;
         pos_ff  <= cnt_ff;
         mode_ff <= pop_blk.mode;
         last_ff <= (cnt_ff == POS_W'(PIXELS - 1));
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_red            = pix_ff[0];
   assign rsp_green          = pix_ff[1];
   assign rsp_blue           = pix_ff[2];
   assign rsp_pixel_position = pos_ff;
   assign rsp_block_mode     = mode_ff;
   assign rsp_last_pixel     = last_ff;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Block-level bench for the ETC2 RGB block decoder. A short table of crafted
// blocks exercises every mode, the clamps at both ends, both sub-block
// splits and both orderings of the H-mode base colors. A few rows carry a
// hand-written expected color; the rest, and several hundred random blocks
// spread evenly over the five modes, are checked against an in-bench decoder.
// Both channels idle and stall in random bursts. The result side also holds
// off once for a long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_top;
   import etc2_pkg::*;

   localparam int N_DIRECTED      = 16;
   localparam int TOTAL_BLOCKS    = 400;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 32;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;

   // modifier magnitudes per intensity table, table 0 in the low byte
   localparam logic [63:0] SMALL_STEPS =
      {8'd47, 8'd33, 8'd24, 8'd18, 8'd13, 8'd9, 8'd5, 8'd2};
   localparam logic [63:0] LARGE_STEPS =
      {8'd183, 8'd106, 8'd80, 8'd60, 8'd42, 8'd29, 8'd17, 8'd8};
   // T and H paint distances, index 0 in the low byte
   localparam logic [63:0] PAINT_DISTANCES =
      {8'd64, 8'd41, 8'd32, 8'd23, 8'd16, 8'd11, 8'd6, 8'd3};

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [POS_W-1:0]  position;
      logic [MODE_W-1:0] mode;
      logic              last;
   } pixel_type;

   // typed rows give one color for all sixteen pixels
   typedef struct packed {
      logic [BLOCK_W-1:0] word;
      logic               typed;
      logic [MODE_W-1:0]  mode;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } block_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BLOCK_W-1:0]   req_block_word = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHAN_W-1:0]    rsp_red;
   logic [CHAN_W-1:0]    rsp_green;
   logic [CHAN_W-1:0]    rsp_blue;
   logic [POS_W-1:0]     rsp_pixel_position;
   logic [MODE_W-1:0]    rsp_block_mode;
   logic                 rsp_last_pixel;

   pixel_type     pending_pixels [$];
   block_row_type directed_rows [N_DIRECTED];
   int            blocks_accepted = 0;
   int            mismatches = 0;
   int            cycle_count = 0;

   etc2_rgb_block_decoder_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_block_word     (req_block_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_pixel_position (rsp_pixel_position),
      .rsp_block_mode     (rsp_block_mode),
      .rsp_last_pixel     (rsp_last_pixel)
   );

   always #5 clock = ~clock;

   // replicate the top bits of a short channel into an 8-bit one
   function automatic int widen(input int v, input int bits);
      return (v << (8 - bits)) | (v >> (2 * bits - 8));
   endfunction

   function automatic logic [CHAN_W-1:0] saturate(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   // mode follows the diff bit and the overflow of each differential sum
   function automatic logic [MODE_W-1:0] block_mode_of(input logic [BLOCK_W-1:0] w);
      int red_sum, green_sum, blue_sum;
      red_sum   = int'(w[63:59]) + int'($signed(w[58:56]));
      green_sum = int'(w[55:51]) + int'($signed(w[50:48]));
      blue_sum  = int'(w[47:43]) + int'($signed(w[42:40]));
      if (!w[33]) return MODE_INDIV;
      if (red_sum < 0 || red_sum > 31) return MODE_T;
      if (green_sum < 0 || green_sum > 31) return MODE_H;
      if (blue_sum < 0 || blue_sum > 31) return MODE_PLANAR;
      return MODE_DIFF;
   endfunction

   // decode one block and queue its sixteen pixels in column-major order
   function automatic void predict_block(input logic [BLOCK_W-1:0] w);
      logic [MODE_W-1:0] mode;
      int                base [3][3];
      int                paint [4][3];
      int                tbl [2];
      int                paint_step, sel, mag, x, y, ch, i;
      logic [1:0]        pick;
      logic [23:0]       first_rgb, second_rgb;
      logic [CHAN_W-1:0] rgb [3];
      mode = block_mode_of(w);
      case (mode)
         MODE_INDIV: begin
            base[0][0] = widen(w[63:60], 4); base[1][0] = widen(w[59:56], 4);
            base[0][1] = widen(w[55:52], 4); base[1][1] = widen(w[51:48], 4);
            base[0][2] = widen(w[47:44], 4); base[1][2] = widen(w[43:40], 4);
         end
         MODE_DIFF: begin
            base[0][0] = widen(w[63:59], 5);
            base[0][1] = widen(w[55:51], 5);
            base[0][2] = widen(w[47:43], 5);
            base[1][0] = widen(int'(w[63:59]) + int'($signed(w[58:56])), 5);
            base[1][1] = widen(int'(w[55:51]) + int'($signed(w[50:48])), 5);
            base[1][2] = widen(int'(w[47:43]) + int'($signed(w[42:40])), 5);
         end
         MODE_T: begin
            base[0][0] = widen({w[60:59], w[57:56]}, 4);
            base[0][1] = widen(w[55:52], 4); base[0][2] = widen(w[51:48], 4);
            base[1][0] = widen(w[47:44], 4); base[1][1] = widen(w[43:40], 4);
            base[1][2] = widen(w[39:36], 4);
            paint_step = PAINT_DISTANCES[8 * int'({w[35:34], w[32]}) +: 8];
            for (ch = 0; ch < 3; ch++) begin
               paint[0][ch] = base[0][ch];
               paint[1][ch] = saturate(base[1][ch] + paint_step);
               paint[2][ch] = base[1][ch];
               paint[3][ch] = saturate(base[1][ch] - paint_step);
            end
         end
         MODE_H: begin
            base[0][0] = widen(w[62:59], 4);
            base[0][1] = widen({w[58:56], w[52]}, 4);
            base[0][2] = widen({w[51], w[49:47]}, 4);
            base[1][0] = widen(w[46:43], 4); base[1][1] = widen(w[42:39], 4);
            base[1][2] = widen(w[38:35], 4);
            first_rgb  = {8'(base[0][0]), 8'(base[0][1]), 8'(base[0][2])};
            second_rgb = {8'(base[1][0]), 8'(base[1][1]), 8'(base[1][2])};
            // the order of the two base colors gives the low distance bit
            paint_step =
               PAINT_DISTANCES[8 * int'({w[34], w[32], first_rgb >= second_rgb}) +: 8];
            for (ch = 0; ch < 3; ch++) begin
               paint[0][ch] = saturate(base[0][ch] + paint_step);
               paint[1][ch] = saturate(base[0][ch] - paint_step);
               paint[2][ch] = saturate(base[1][ch] + paint_step);
               paint[3][ch] = saturate(base[1][ch] - paint_step);
            end
         end
         default: begin
            // planar: origin, horizontal and vertical colors
            base[0][0] = widen(w[62:57], 6);
            base[0][1] = widen({w[56], w[54:49]}, 7);
            base[0][2] = widen({w[48], w[44:43], w[41:39]}, 6);
            base[1][0] = widen({w[38:34], w[32]}, 6);
            base[1][1] = widen(w[31:25], 7);
            base[1][2] = widen(w[24:19], 6);
            base[2][0] = widen(w[18:13], 6);
            base[2][1] = widen(w[12:6], 7);
            base[2][2] = widen(w[5:0], 6);
         end
      endcase
      tbl[0] = int'(w[39:37]);
      tbl[1] = int'(w[36:34]);
      for (i = 0; i < PIXELS; i++) begin
         pick = {w[i + 16], w[i]};
         x = i >> 2;
         y = i & 3;
         for (ch = 0; ch < 3; ch++) begin
            case (mode)
               MODE_INDIV, MODE_DIFF: begin
                  // flip bit splits the block into top/bottom, else left/right
                  sel = w[32] ? (y >> 1) : (x >> 1);
                  mag = pick[0] ? int'(LARGE_STEPS[8 * tbl[sel] +: 8])
                                : int'(SMALL_STEPS[8 * tbl[sel] +: 8]);
                  rgb[ch] = saturate(pick[1] ? base[sel][ch] - mag : base[sel][ch] + mag);
               end
               MODE_T, MODE_H: begin
                  rgb[ch] = 8'(paint[pick][ch]);
               end
               default: begin
                  // floor division by four, then clamp
                  rgb[ch] = saturate((x * (base[1][ch] - base[0][ch])
                                      + y * (base[2][ch] - base[0][ch])
                                      + 4 * base[0][ch] + 2) >>> 2);
               end
            endcase
         end
         pending_pixels.push_back({rgb[0], rgb[1], rgb[2], 4'(i), mode, i == PIXELS - 1});
      end
   endfunction

   // stretches with no random idle or stall bursts, including the end of the run
   function automatic bit steady_stretch();
      return blocks_accepted >= TOTAL_BLOCKS - 40 || (blocks_accepted / 24) % 3 == 1;
   endfunction

   // offer one block, maybe after an idle burst, and hold it until taken
   task automatic offer_block(input logic [BLOCK_W-1:0] word);
      if (!steady_stretch() && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_block_word <= word;
      do @(posedge clock); while (!req_ready);
      blocks_accepted++;
   endtask

   // drive reset, the directed table, then random blocks; judge the run
   initial begin
      logic [BLOCK_W-1:0] w;
      logic [MODE_W-1:0]  target;
      int                 n, i;
      directed_rows = '{
         '{64'h0000_0000_0000_0000, 1'b1, MODE_INDIV,  8'd2,   8'd2,   8'd2},
         '{64'hFFFF_FFFC_0000_FFFF, 1'b1, MODE_INDIV,  8'd255, 8'd255, 8'd255},
         '{64'h0000_00FC_FFFF_FFFF, 1'b1, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'hFB00_0002_0000_0000, 1'b1, MODE_T,      8'd255, 8'd0,   8'd0},
         '{64'hF00F_F0A5_5555_AAAA, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'h0303_03E2_FFFF_0000, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'hFC84_275B_1234_ABCD, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'hFB00_FFFF_FF00_F0F0, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'hFB00_0007_00FF_FF00, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'h04A5_5A5A_1234_5678, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'h00F9_0002_0000_0000, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'h00F9_7802_3C3C_C3C3, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'h8804_A5FE_F00F_0FF0, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'h0000_047F_FFFF_FFFF, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0},
         '{64'h7F7F_FB82_0000_0000, 1'b0, MODE_INDIV,  8'd0,   8'd0,   8'd0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks: typed rows carry their own expected color
      for (n = 0; n < N_DIRECTED; n++) begin
         offer_block(directed_rows[n].word);
         if (directed_rows[n].typed) begin
            for (i = 0; i < PIXELS; i++)
               pending_pixels.push_back({directed_rows[n].red, directed_rows[n].green,
                                         directed_rows[n].blue, 4'(i),
                                         directed_rows[n].mode, i == PIXELS - 1});
         end else begin
            predict_block(directed_rows[n].word);
         end
      end

      // random blocks, the mode picked first and then hit by redrawing
      for (n = N_DIRECTED; n < TOTAL_BLOCKS; n++) begin
         target = MODE_W'($urandom_range(MODE_INDIV, MODE_PLANAR));
         do begin
            w = {$urandom, $urandom};
            w[33] = (target != MODE_INDIV);
         end while (block_mode_of(w) != target);
         offer_block(w);
         predict_block(w);
      end
      req_valid <= 1'b0;

      // drain, then allow for stray pixels
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // result side: random stall bursts and one long hold-off
   initial begin
      bit held_off;
      held_off = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held_off && blocks_accepted >= 30) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!steady_stretch() && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each accepted pixel with the oldest one pending
   always @(posedge clock) begin
      pixel_type seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_red, rsp_green, rsp_blue, rsp_pixel_position, rsp_block_mode,
                 rsp_last_pixel};
         if (pending_pixels.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("unexpected pixel: r%0d g%0d b%0d pos %0d mode %0d last %0d",
                        seen.red, seen.green, seen.blue, seen.position, seen.mode,
                        seen.last);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (seen !== want) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("pixel mismatch: expected r%0d g%0d b%0d pos %0d mode %0d last %0d",
                           want.red, want.green, want.blue, want.position, want.mode,
                           want.last);
                  $display("                got      r%0d g%0d b%0d pos %0d mode %0d last %0d",
                           seen.red, seen.green, seen.blue, seen.position, seen.mode,
                           seen.last);
               end
               mismatches++;
            end
         end
      end
   end

   // end a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
